FILE: rtl/core/emghs_pkg.sv
// Shared types and constants for the EMG hand servo controller.
package emghs_pkg;

  // Field widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PulseW  = 12;
  localparam int unsigned StepW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW = 96;
  localparam int unsigned OutDataW = 80;

  // Fixed servo pulse widths in microseconds.
  localparam logic [PulseW-1:0] PulseClosed     = 12'd500;
  localparam logic [PulseW-1:0] PulseNeutral    = 12'd1510;
  localparam logic [PulseW-1:0] PulseOpen       = 12'd2388;
  localparam logic [PulseW-1:0] PulseLittleOpen = 12'd1722;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    RegGripThreshold   = 3'd0,
    RegActiveThreshold = 3'd1,
    RegModePulseMin    = 3'd2,
    RegModePulseMax    = 3'd3,
    RegWristStep       = 3'd4,
    RegWristMin        = 3'd5,
    RegWristMax        = 3'd6
  } cfg_reg_e;

  // Configuration register file contents.
  typedef struct packed {
    logic [SampleW-1:0] grip_threshold;
    logic [SampleW-1:0] active_threshold;
    logic [SampleW-1:0] mode_pulse_min_ms;
    logic [SampleW-1:0] mode_pulse_max_ms;
    logic [StepW-1:0]   wrist_step_us;
    logic [PulseW-1:0]  wrist_min_us;
    logic [PulseW-1:0]  wrist_max_us;
  } cfg_t;

  // One input frame.
  typedef struct packed {
    logic [TimeW-1:0]   time_ms;
    logic [SampleW-1:0] mode_sample;
    logic [SampleW-1:0] counter_sample;
    logic [SampleW-1:0] clockwise_sample;
    logic [SampleW-1:0] grip_sample;
  } in_item_t;

  // Mode detector status toward the top level.
  typedef struct packed {
    logic five_next;
    logic five_q;
  } mode_stat_t;

  // Finger pulse set.
  typedef struct packed {
    logic [PulseW-1:0] little;
    logic [PulseW-1:0] ring;
    logic [PulseW-1:0] middle;
    logic [PulseW-1:0] index;
    logic [PulseW-1:0] thumb;
  } fingers_t;

endpackage

FILE: rtl/core/emghs_mode.sv
// Mode pulse detector: times pulses on the mode channel and toggles the hand mode.
module emghs_mode
  import emghs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cfg_t               cfg_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [TimeW-1:0]   time_i,
  output mode_stat_t         stat_o
);

  logic             mode_five_q, mode_five_d;
  logic             pulse_active_q, pulse_active_d;
  logic             last_active_q, last_active_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             act;
  logic [TimeW-1:0] dur;
  logic             in_window;

  // Pulse length in modular time and the inclusive window test.
  assign act       = sample_i > cfg_i.active_threshold;
  assign dur       = time_i - start_q;
  assign in_window = (dur >= {16'd0, cfg_i.mode_pulse_min_ms}) &&
                     (dur <= {16'd0, cfg_i.mode_pulse_max_ms});

  // Next state for the current frame.
  always_comb begin
    mode_five_d    = mode_five_q;
    pulse_active_d = pulse_active_q;
    start_d        = start_q;
    if (act && !last_active_q && !pulse_active_q) begin
      start_d        = time_i;
      pulse_active_d = 1'b1;
    end else if (!act && pulse_active_q) begin
      if (in_window) begin
        mode_five_d = !mode_five_q;
      end
      pulse_active_d = 1'b0;
    end
    last_active_d = act;
  end

  // State advances once per frame that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_five_q    <= 1'b1;
      pulse_active_q <= 1'b0;
      last_active_q  <= 1'b0;
      start_q        <= '0;
    end else if (step_i) begin
      mode_five_q    <= mode_five_d;
      pulse_active_q <= pulse_active_d;
      last_active_q  <= last_active_d;
      start_q        <= start_d;
    end
  end

  assign stat_o.five_next = mode_five_d;
  assign stat_o.five_q    = mode_five_q;

endmodule

FILE: rtl/core/emghs_wrist.sv
// Wrist stepper: moves the wrist pulse up and down with saturation at the limits.
module emghs_wrist
  import emghs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cfg_t               cfg_i,
  input  logic [SampleW-1:0] cw_sample_i,
  input  logic [SampleW-1:0] ccw_sample_i,
  output logic [PulseW-1:0]  wrist_o
);

  logic [PulseW-1:0] wrist_q, wrist_d;
  logic [PulseW-1:0] up_val;
  logic [PulseW:0]   sum;
  logic [PulseW:0]   diff;

  // Clockwise step first, clipped at the upper limit.
  assign sum = {1'b0, wrist_q} + {{(PulseW+1-StepW){1'b0}}, cfg_i.wrist_step_us};

  always_comb begin
    up_val = wrist_q;
    if ((cw_sample_i > cfg_i.active_threshold) && (wrist_q < cfg_i.wrist_max_us)) begin
      if (sum > {1'b0, cfg_i.wrist_max_us}) begin
        up_val = cfg_i.wrist_max_us;
      end else begin
        up_val = sum[PulseW-1:0];
      end
    end
  end

  // Counterclockwise step on the result, clipped at the lower limit.
  assign diff = {1'b0, up_val} - {{(PulseW+1-StepW){1'b0}}, cfg_i.wrist_step_us};

  always_comb begin
    wrist_d = up_val;
    if ((ccw_sample_i > cfg_i.active_threshold) && (up_val > cfg_i.wrist_min_us)) begin
      if (diff[PulseW] || (diff[PulseW-1:0] < cfg_i.wrist_min_us)) begin
        wrist_d = cfg_i.wrist_min_us;
      end else begin
        wrist_d = diff[PulseW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrist_q <= PulseNeutral;
    end else if (step_i) begin
      wrist_q <= wrist_d;
    end
  end

  assign wrist_o = wrist_d;

endmodule

FILE: rtl/core/emghs_grip.sv
// Grip decoder: turns the grip channel and hand mode into finger pulses.
module emghs_grip
  import emghs_pkg::*;
(
  input  cfg_t               cfg_i,
  input  logic [SampleW-1:0] grip_sample_i,
  input  logic               mode_five_i,
  output fingers_t           fingers_o
);

  logic              closed;
  logic [PulseW-1:0] drive;

  assign closed = grip_sample_i > cfg_i.grip_threshold;
  assign drive  = closed ? PulseClosed : PulseOpen;

  // Thumb and index always follow the grip; the rest depend on the mode.
  always_comb begin
    fingers_o.thumb = drive;
    fingers_o.index = drive;
    if (mode_five_i) begin
      fingers_o.middle = drive;
      fingers_o.ring   = drive;
      fingers_o.little = closed ? PulseClosed : PulseLittleOpen;
    end else begin
      fingers_o.middle = PulseNeutral;
      fingers_o.ring   = PulseNeutral;
      fingers_o.little = PulseNeutral;
    end
  end

endmodule

FILE: rtl/core/emg_hand_servo_controller_core.sv
// Top level of the EMG hand servo controller: ports, registers and pipeline control.
//
// Channel   | Dir | Beat content
// s_axis    | in  | tdata: grip, clockwise, counter, mode samples (16 b each), time_ms (32 b)
// m_axis    | out | tdata: thumb, index, middle, ring, little, wrist (12 b each), five-finger bit
// cfg       | in  | cfg_we_i, cfg_index_i, cfg_wdata_i: one register write per cycle
//
// A frame passes from the input beat into the input register; the state update and result
// computation then land in the output register. One frame per cycle is sustained unless
// m_axis_tready stalls the output; the state update in the output stage sets that figure.
// Reset restores all but the payload registers to defaults: five-finger mode, neutral wrist.
// A stalled output holds its beat; the input register still takes a frame while empty.
module emg_hand_servo_controller_core
  import emghs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input frames.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] grip_sample, [31:16] clockwise_sample, [47:32] counter_sample,
  // [63:48] mode_sample, [95:64] time_ms
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Results.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [11:0] thumb_pulse, [23:12] index_pulse, [35:24] middle_pulse, [47:36] ring_pulse,
  // [59:48] little_pulse, [71:60] wrist_pulse_out, [72] five_finger_mode, [79:73] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  cfg_t              cfg_q;
  logic              in_valid_q;
  in_item_t          in_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_q, out_d;
  logic              move;
  mode_stat_t        mode_stat;
  logic [PulseW-1:0] wrist;
  fingers_t          fingers;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grip_threshold    <= 16'd2000;
      cfg_q.active_threshold  <= 16'd30000;
      cfg_q.mode_pulse_min_ms <= 16'd400;
      cfg_q.mode_pulse_max_ms <= 16'd600;
      cfg_q.wrist_step_us     <= 8'd20;
      cfg_q.wrist_min_us      <= 12'd500;
      cfg_q.wrist_max_us      <= 12'd2500;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegGripThreshold:   cfg_q.grip_threshold    <= cfg_wdata_i;
        RegActiveThreshold: cfg_q.active_threshold  <= cfg_wdata_i;
        RegModePulseMin:    cfg_q.mode_pulse_min_ms <= cfg_wdata_i;
        RegModePulseMax:    cfg_q.mode_pulse_max_ms <= cfg_wdata_i;
        RegWristStep:       cfg_q.wrist_step_us     <= cfg_wdata_i[StepW-1:0];
        RegWristMin:        cfg_q.wrist_min_us      <= cfg_wdata_i[PulseW-1:0];
        RegWristMax:        cfg_q.wrist_max_us      <= cfg_wdata_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a frame moves on when the output register is free or drains.
  assign move          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_item_t'(s_axis_tdata);
    end
  end

  emghs_mode u_mode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (move),
    .cfg_i    (cfg_q),
    .sample_i (in_q.mode_sample),
    .time_i   (in_q.time_ms),
    .stat_o   (mode_stat)
  );

  emghs_wrist u_wrist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (move),
    .cfg_i        (cfg_q),
    .cw_sample_i  (in_q.clockwise_sample),
    .ccw_sample_i (in_q.counter_sample),
    .wrist_o      (wrist)
  );

  emghs_grip u_grip (
    .cfg_i         (cfg_q),
    .grip_sample_i (in_q.grip_sample),
    .mode_five_i   (mode_stat.five_next),
    .fingers_o     (fingers)
  );

  // Result packing and output register.
  assign out_d = {7'd0, mode_stat.five_next, wrist, fingers};

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  // Two-finger results always park the middle finger at neutral.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[72]) |-> (m_axis_tdata[35:24] == PulseNeutral))
    else $error("middle finger not neutral in two-finger mode");

  // The hand mode only changes when a frame passes into the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> $stable(mode_stat.five_q))
    else $error("mode changed without a frame");

  // An empty input register always takes a new beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while input register empty");

  // A frame leaving the input stage always yields a valid result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> m_axis_tvalid)
    else $error("result lost after frame moved");
`endif

endmodule
